// File: rtl/tks_pkg.sv
// Shared widths, register indexes and cell control type for the top-k selector.
package tks_pkg;

  localparam int DATA_W     = 32;
  localparam int POS_OUT_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int KCFG_W     = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_KEPT      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_SMALLEST = 1'd1;

  typedef struct packed {
    logic load;       // insert the element on the shared bus
    logic shift_out;  // move every slot one place towards the head
    logic smallest;   // rank smaller values ahead
  } cell_ctrl_t;

endpackage

// File: rtl/top_k_select_with_index_core.sv
// Top level of the streaming top-k selector with positions.
// Elements of a column arrive one per transfer on the in_ channel and enter a
// chain of K_MAX rank cells, one element per cycle, each cell holding one kept
// value and its column position in rank order. On the element marked tlast
// the input stalls while the chain drains from its head, one pair per out_
// transfer, best first, out_tlast on the last pair. Ties rank the earlier
// element first. count_kept of 0 acts as 1, above K_MAX as K_MAX.
module top_k_select_with_index_core #(
  parameter int K_MAX      = 16,
  parameter int COLUMN_MAX = 65536,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tks_pkg::DATA_W-1:0]        in_tdata,   // element_value
  input  logic                              in_tlast,   // column_end
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [47:0]                       out_tdata,  // chosen_value, chosen_position
  output logic                              out_tlast,  // final_pair
  input  logic                              cfg_we,
  input  logic [tks_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tks_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int POS_W = $clog2(COLUMN_MAX);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(COLUMN_MAX - 1);
  localparam logic [tks_pkg::KCFG_W-1:0] KMAX_K = tks_pkg::KCFG_W'(K_MAX);

  logic [tks_pkg::KCFG_W-1:0] count_kept_r;
  logic                       smallest_r;
  logic [POS_W-1:0]           counter_r, counter_nxt;
  logic                       draining_r, draining_nxt;
  logic [tks_pkg::KCFG_W-1:0] k_eff;
  logic                       in_xfer, out_xfer;
  logic [VALUE_BITS-1:0]      new_value;
  tks_pkg::cell_ctrl_t        ctrl;

  logic [VALUE_BITS-1:0] cell_value [K_MAX];
  logic [POS_W-1:0]      cell_pos   [K_MAX];
  logic                  cell_valid [K_MAX];
  logic                  cell_found [K_MAX];
  logic                  head_next_valid;

  assign in_tready = !draining_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;
  assign new_value = VALUE_BITS'(in_tdata);

  always_comb begin
    if (count_kept_r == '0) begin
      k_eff = tks_pkg::KCFG_W'(1);
    end else if (count_kept_r > KMAX_K) begin
      k_eff = KMAX_K;
    end else begin
      k_eff = count_kept_r;
    end
  end

  assign ctrl.load      = in_xfer;
  assign ctrl.shift_out = out_xfer;
  assign ctrl.smallest  = smallest_r;

  genvar gi;
  generate
    for (gi = 0; gi < K_MAX; gi++) begin : g_cell
      logic [VALUE_BITS-1:0] l_value, r_value;
      logic [POS_W-1:0]      l_pos, r_pos;
      logic                  l_valid, r_valid, f_in;

      if (gi == 0) begin : g_head
        assign l_value = '0;
        assign l_pos   = '0;
        assign l_valid = 1'b0;
        assign f_in    = 1'b0;
      end else begin : g_body
        assign l_value = cell_value[gi-1];
        assign l_pos   = cell_pos[gi-1];
        assign l_valid = cell_valid[gi-1];
        assign f_in    = cell_found[gi-1];
      end

      if (gi == K_MAX - 1) begin : g_tail
        assign r_value = '0;
        assign r_pos   = '0;
        assign r_valid = 1'b0;
      end else begin : g_inner
        assign r_value = cell_value[gi+1];
        assign r_pos   = cell_pos[gi+1];
        assign r_valid = cell_valid[gi+1];
      end

      tks_cell #(
        .VALUE_BITS(VALUE_BITS),
        .POS_W     (POS_W)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .active     (tks_pkg::KCFG_W'(gi) < k_eff),
        .new_value  (new_value),
        .new_pos    (counter_r),
        .found_in   (f_in),
        .found_out  (cell_found[gi]),
        .left_value (l_value),
        .left_pos   (l_pos),
        .left_valid (l_valid),
        .right_value(r_value),
        .right_pos  (r_pos),
        .right_valid(r_valid),
        .value      (cell_value[gi]),
        .pos        (cell_pos[gi]),
        .valid      (cell_valid[gi])
      );
    end

    if (K_MAX > 1) begin : g_next
      assign head_next_valid = cell_valid[1];
    end else begin : g_single
      assign head_next_valid = 1'b0;
    end
  endgenerate

  assign out_tvalid       = draining_r;
  assign out_tdata[31:0]  = tks_pkg::DATA_W'($signed(cell_value[0]));
  assign out_tdata[47:32] = tks_pkg::POS_OUT_W'(cell_pos[0]);
  assign out_tlast        = !head_next_valid;

  always_comb begin
    counter_nxt  = counter_r;
    draining_nxt = draining_r;
    if (in_xfer) begin
      if (in_tlast) begin
        counter_nxt  = '0;
        draining_nxt = 1'b1;
      end else if (counter_r == POS_LAST) begin
        counter_nxt = '0;
      end else begin
        counter_nxt = counter_r + POS_W'(1);
      end
    end else if (out_xfer && !head_next_valid) begin
      draining_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_kept_r <= tks_pkg::KCFG_W'(1);
      smallest_r   <= 1'b0;
      counter_r    <= '0;
      draining_r   <= 1'b0;
    end else begin
      counter_r  <= counter_nxt;
      draining_r <= draining_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tks_pkg::CFG_COUNT_KEPT:      count_kept_r <= cfg_wdata;
          tks_pkg::CFG_SELECT_SMALLEST: smallest_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/tks_cell.sv
// One rank slot of the selection chain: compare, keep, insert or shift.
module tks_cell #(
  parameter int VALUE_BITS = 32,
  parameter int POS_W      = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tks_pkg::cell_ctrl_t    ctrl,
  input  logic                   active,
  input  logic [VALUE_BITS-1:0]  new_value,
  input  logic [POS_W-1:0]       new_pos,
  input  logic                   found_in,
  output logic                   found_out,
  input  logic [VALUE_BITS-1:0]  left_value,
  input  logic [POS_W-1:0]       left_pos,
  input  logic                   left_valid,
  input  logic [VALUE_BITS-1:0]  right_value,
  input  logic [POS_W-1:0]       right_pos,
  input  logic                   right_valid,
  output logic [VALUE_BITS-1:0]  value,
  output logic [POS_W-1:0]       pos,
  output logic                   valid
);

  localparam logic [VALUE_BITS-1:0] SIGN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  valid_r, valid_nxt;
  logic [VALUE_BITS-1:0] key_new, key_own;
  logic                  ahead, beats;

  assign key_new   = new_value ^ SIGN;
  assign key_own   = value_r ^ SIGN;
  assign ahead     = ctrl.smallest ? (key_new < key_own) : (key_new > key_own);
  assign beats     = !valid_r || ahead;
  assign found_out = found_in || beats;

  always_comb begin
    value_nxt = value_r;
    pos_nxt   = pos_r;
    valid_nxt = valid_r;
    if (ctrl.load) begin
      if (!active) begin
        valid_nxt = 1'b0;
      end else if (found_in) begin
        value_nxt = left_value;
        pos_nxt   = left_pos;
        valid_nxt = left_valid;
      end else if (beats) begin
        value_nxt = new_value;
        pos_nxt   = new_pos;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.shift_out) begin
      value_nxt = right_value;
      pos_nxt   = right_pos;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    pos_r   <= pos_nxt;
  end

  assign value = value_r;
  assign pos   = pos_r;
  assign valid = valid_r;

endmodule
